>>> sv/bmpage_pkg.sv
// Shared constants, register codes and types of the bitmap row to page byte converter.
package bmpage_pkg;

  localparam int MAX_WIDTH_BYTES = 16;
  localparam int PIX_W           = 8;
  localparam int ROWS_STORED     = 7;
  localparam int BAND_ROWS       = 8;
  localparam int WIDTH_W         = 5;
  localparam int BANDS_W         = 6;
  localparam int BAND_IDX_W      = 5;
  localparam int MAX_BANDS       = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(16);
  localparam logic [BANDS_W-1:0] BANDS_RESET = BANDS_W'(8);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT  = CFG_IDX_W'(1);

  // One finished byte column of a band, ready for serialization.
  typedef struct packed {
    logic [BAND_ROWS*PIX_W-1:0] rows;
    logic                       last_image;
  } col_load_t;

endpackage

>>> sv/bmpage_pix_if.sv
// Input channel: one bitmap byte per item.
interface bmpage_pix_if;
  logic                            valid;
  logic                            ready;
  logic [bmpage_pkg::PIX_W-1:0]    pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

>>> sv/bmpage_col_if.sv
// Result channel: one column byte per item with run and image end flags.
interface bmpage_col_if;
  logic                            valid;
  logic                            ready;
  logic [bmpage_pkg::PIX_W-1:0]    column_byte;
  logic                            last_of_run;
  logic                            last_of_image;

  modport source (output valid, output column_byte, output last_of_run,
                  output last_of_image, input ready);
  modport sink   (input valid, input column_byte, input last_of_run,
                  input last_of_image, output ready);
endinterface

>>> sv/bmpage_cfg_if.sv
// Configuration write channel: register index and write data.
interface bmpage_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmpage_pkg::CFG_IDX_W-1:0]     index;
  logic [bmpage_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/bmpage_core_top.sv
// Top level of the bitmap row to page byte converter.
// Bitmap bytes come in row-major order, most significant bit leftmost. Bytes of band
// rows 0..6 are written into the band store at one per cycle while the staging register
// is empty. A byte of row 7 reads its byte column back from the store (registered read),
// lands in a one-item staging register and then goes to a shift-register serializer that
// gives eight column bytes, one per cycle while the output is ready, leftmost pixel column
// first. No byte is taken while the staging register holds an item that waits for the
// serializer. The store needs no clearing after reset; widths and band counts out of
// range are clamped, and counters wrap to a new image after the last byte of the last
// band.
module bitmap_row_to_page_bytes_core #(
  parameter int MaxWidthBytes = bmpage_pkg::MAX_WIDTH_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  bmpage_pix_if.sink    in_pix,
  bmpage_col_if.source  out_col,
  bmpage_cfg_if.sink    cfg_port
);

  localparam int ColW = (MaxWidthBytes > 1) ? $clog2(MaxWidthBytes) : 1;
  localparam int CmpW = 8;
  localparam int BIdxW = bmpage_pkg::BAND_IDX_W;
  localparam int BandsW = bmpage_pkg::BANDS_W;
  localparam int StW = bmpage_pkg::ROWS_STORED * bmpage_pkg::PIX_W;

  logic [bmpage_pkg::WIDTH_W-1:0] width_bytes_r;
  logic [BandsW-1:0]              band_count_r;

  logic [2:0]       row_r;
  logic [ColW-1:0]  col_r;
  logic [BIdxW-1:0] band_r;

  logic                        pend_valid_r;
  logic [bmpage_pkg::PIX_W-1:0] pend_pix_r;
  logic                        pend_last_r;
  logic [StW-1:0]              store_rows;

  logic [CmpW-1:0]   weff;
  logic [BandsW-1:0] nbeff;
  logic [ColW-1:0]   col_eff;
  logic              last_col;
  logic              last_band;
  logic              in_take;
  logic              row_last;
  logic              load_ready;
  bmpage_pkg::col_load_t load;

  // Configuration; nothing is taken while reset is held
  assign cfg_port.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_bytes_r <= bmpage_pkg::WIDTH_RESET;
      band_count_r  <= bmpage_pkg::BANDS_RESET;
    end else if (cfg_port.valid) begin
      if (cfg_port.index == bmpage_pkg::CFG_WIDTH_BYTES) begin
        width_bytes_r <= cfg_port.data[bmpage_pkg::WIDTH_W-1:0];
      end else if (cfg_port.index == bmpage_pkg::CFG_BAND_COUNT) begin
        band_count_r <= cfg_port.data[BandsW-1:0];
      end
    end
  end

  // Position within the image
  always_comb begin
    if (width_bytes_r == '0) begin
      weff = CmpW'(1);
    end else if (CmpW'(width_bytes_r) > CmpW'(MaxWidthBytes)) begin
      weff = CmpW'(MaxWidthBytes);
    end else begin
      weff = CmpW'(width_bytes_r);
    end

    if (band_count_r == '0) begin
      nbeff = BandsW'(1);
    end else if (band_count_r > BandsW'(bmpage_pkg::MAX_BANDS)) begin
      nbeff = BandsW'(bmpage_pkg::MAX_BANDS);
    end else begin
      nbeff = band_count_r;
    end

    col_eff   = (CmpW'(col_r) >= weff) ? '0 : col_r;
    last_col  = (CmpW'(col_eff) + CmpW'(1) >= weff);
    last_band = (BandsW'(band_r) + BandsW'(1) >= nbeff);
  end

  assign row_last     = (row_r == 3'(bmpage_pkg::ROWS_STORED));
  assign in_pix.ready = rst_n && !pend_valid_r;
  assign in_take      = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      band_r <= '0;
    end else if (in_take) begin
      if (last_col) begin
        col_r <= '0;
        if (row_last) begin
          row_r  <= '0;
          band_r <= last_band ? '0 : band_r + 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end else begin
        col_r <= col_eff + 1'b1;
      end
    end
  end

  bmpage_band_store #(
    .Depth (MaxWidthBytes)
  ) u_store (
    .clk    (clk),
    .wr_en  (in_take && !row_last),
    .rd_en  (in_take && row_last),
    .col    (col_eff),
    .row    (row_r),
    .pix    (in_pix.pixel_byte),
    .rows_r (store_rows)
  );

  // Staging register for a row 7 item, waits while the serializer is busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_take && row_last) begin
      pend_valid_r <= 1'b1;
    end else if (load_ready) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && row_last) begin
      pend_pix_r  <= in_pix.pixel_byte;
      pend_last_r <= last_col && last_band;
    end
  end

  assign load.rows       = {pend_pix_r, store_rows};
  assign load.last_image = pend_last_r;

  bmpage_col_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (pend_valid_r),
    .load_ready (load_ready),
    .load       (load),
    .out_col    (out_col)
  );

endmodule

>>> sv/bmpage_band_store.sv
// Band store: rows 0..6 of the current band, one byte lane per row, registered read.
module bmpage_band_store #(
  parameter int Depth = bmpage_pkg::MAX_WIDTH_BYTES
) (
  input  logic                                                  clk,
  input  logic                                                  wr_en,
  input  logic                                                  rd_en,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0]            col,
  input  logic [2:0]                                            row,
  input  logic [bmpage_pkg::PIX_W-1:0]                          pix,
  output logic [bmpage_pkg::ROWS_STORED*bmpage_pkg::PIX_W-1:0]  rows_r
);

  logic [bmpage_pkg::PIX_W-1:0] mem [Depth][bmpage_pkg::ROWS_STORED];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col][row] <= pix;
    end
    if (rd_en) begin
      for (int r = 0; r < bmpage_pkg::ROWS_STORED; r++) begin
        rows_r[r*bmpage_pkg::PIX_W +: bmpage_pkg::PIX_W] <= mem[col][r];
      end
    end
  end

endmodule

>>> sv/bmpage_col_ser.sv
// Column serializer: eight row lanes shifted left, one column byte per item out.
module bmpage_col_ser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_valid,
  output logic                   load_ready,
  input  bmpage_pkg::col_load_t  load,
  bmpage_col_if.source           out_col
);

  localparam int Lanes = bmpage_pkg::BAND_ROWS;
  localparam int PixW  = bmpage_pkg::PIX_W;

  logic [PixW-1:0]          lane_r [Lanes];
  logic [$clog2(Lanes)-1:0] cnt_r;
  logic                     valid_r;
  logic                     last_image_r;
  logic                     take;
  logic                     last_beat;

  assign last_beat  = (cnt_r == ($clog2(Lanes))'(Lanes - 1));
  assign take       = valid_r && out_col.ready;
  assign load_ready = !valid_r || (take && last_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (load_valid && load_ready) begin
      valid_r <= 1'b1;
      cnt_r   <= '0;
    end else if (take) begin
      cnt_r <= cnt_r + 1'b1;
      if (last_beat) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Payload: lane k holds band row k; the leftmost pixel sits in bit 7.
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      for (int k = 0; k < Lanes; k++) begin
        lane_r[k] <= load.rows[k*PixW +: PixW];
      end
      last_image_r <= load.last_image;
    end else if (take) begin
      for (int k = 0; k < Lanes; k++) begin
        lane_r[k] <= {lane_r[k][PixW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      out_col.column_byte[k] = lane_r[k][PixW-1];
    end
  end

  assign out_col.valid         = valid_r;
  assign out_col.last_of_run   = last_beat;
  assign out_col.last_of_image = last_beat && last_image_r;

endmodule

>>> tb/sv/tb_bitmap_row_to_page_bytes_core.sv
// Self-checking bench for the row-major to page byte converter, with random handshakes.
module tb_bitmap_row_to_page_bytes_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpage_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 460;
  localparam int QUIET_TAIL    = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  // band rows 0..7 of the first directed band, one pattern per row
  localparam logic [PIX_W-1:0] CORNER_BYTES [BAND_ROWS] =
    '{8'h80, 8'h01, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hF0, 8'h0F};

  typedef struct packed {
    logic [PIX_W-1:0] column_byte;
    logic             last_of_run;
    logic             last_of_image;
  } column_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  bmpage_pix_if pix_ch ();
  bmpage_col_if col_ch ();
  bmpage_cfg_if cfg_ch ();

  bitmap_row_to_page_bytes_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_ch),
    .out_col  (col_ch),
    .cfg_port (cfg_ch)
  );

  logic [PIX_W-1:0] pixel_q [$];
  column_item_t     column_bytes_due [$];

  // copy of the band store and counters
  logic [ROWS_STORED*PIX_W-1:0] band_store [MAX_WIDTH_BYTES];
  logic [2:0]                   row_pos;
  logic [3:0]                   col_pos;
  logic [BAND_IDX_W-1:0]        band_pos;
  logic [WIDTH_W-1:0]           width_reg;
  logic [BANDS_W-1:0]           bands_reg;

  logic pix_fire   = 1'b0;
  int   errors     = 0;
  int   cycles     = 0;
  int   idle_odds  = 0;
  int   send_gap   = 0;
  int   stall_left = 0;
  int   items_sent = 0;

  function automatic int clamp_width(logic [WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_BYTES) return MAX_WIDTH_BYTES;
    return int'(w);
  endfunction

  function automatic int clamp_bands(logic [BANDS_W-1:0] b);
    if (b == 0) return 1;
    if (b > MAX_BANDS) return MAX_BANDS;
    return int'(b);
  endfunction

  // Stores a byte of rows 0..6, or turns a row 7 byte and its column into eight column bytes.
  task automatic absorb_pixel_byte(input logic [PIX_W-1:0] pix);
    int                         w;
    int                         nb;
    int                         col;
    int                         c;
    int                         k;
    logic                       last_col;
    logic                       last_band;
    logic [BAND_ROWS*PIX_W-1:0] rows;
    column_item_t               item;
    w   = clamp_width(width_reg);
    nb  = clamp_bands(bands_reg);
    col = int'(col_pos);
    if (col >= w) col = 0;
    last_col  = (col + 1 >= w);
    last_band = (int'(band_pos) + 1 >= nb);
    if (row_pos < ROWS_STORED) begin
      band_store[col][row_pos*PIX_W +: PIX_W] = pix;
    end else begin
      rows = {pix, band_store[col]};
      for (c = 0; c < BAND_ROWS; c++) begin
        for (k = 0; k < BAND_ROWS; k++) begin
          item.column_byte[k] = rows[k*PIX_W + (PIX_W - 1 - c)];
        end
        item.last_of_run   = (c == BAND_ROWS - 1);
        item.last_of_image = (c == BAND_ROWS - 1) && last_col && last_band;
        column_bytes_due.push_back(item);
      end
    end
    if (last_col) begin
      col_pos = '0;
      if (row_pos == BAND_ROWS - 1) begin
        row_pos  = '0;
        band_pos = last_band ? '0 : band_pos + 1'b1;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = 4'(col + 1);
    end
  endtask

  // check results, track register writes, predict from accepted bytes
  always @(posedge clk) begin : monitor
    column_item_t due;
    pix_fire <= pix_ch.valid && pix_ch.ready;
    if (!rst_n) begin
      row_pos   = '0;
      col_pos   = '0;
      band_pos  = '0;
      width_reg = WIDTH_RESET;
      bands_reg = BANDS_RESET;
      column_bytes_due.delete();
    end else begin
      if (col_ch.valid && col_ch.ready) begin
        if (column_bytes_due.size() == 0) begin
          $error("column_byte: expected none, got %02h", col_ch.column_byte);
          errors++;
        end else begin
          due = column_bytes_due.pop_front();
          if (col_ch.column_byte !== due.column_byte) begin
            $error("column_byte: expected %02h, got %02h", due.column_byte, col_ch.column_byte);
            errors++;
          end
          if (col_ch.last_of_run !== due.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", due.last_of_run, col_ch.last_of_run);
            errors++;
          end
          if (col_ch.last_of_image !== due.last_of_image) begin
            $error("last_of_image: expected %0b, got %0b", due.last_of_image,
                   col_ch.last_of_image);
            errors++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_WIDTH_BYTES: width_reg = cfg_ch.data[WIDTH_W-1:0];
          CFG_BAND_COUNT:  bands_reg = cfg_ch.data[BANDS_W-1:0];
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) absorb_pixel_byte(pix_ch.pixel_byte);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bitmap_row_to_page_bytes_core: done, errors");
      $finish;
    end
  end

  // byte driver with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        pix_ch.valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        send_gap = $urandom_range(0, 18);
        pix_ch.valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel_byte <= pixel_q.pop_front();
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      col_ch.ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 18);
      col_ch.ready <= 1'b0;
    end else begin
      col_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) begin
      pixel_q.push_back(PIX_W'($urandom));
      items_sent++;
    end
  endtask

  // hold the sender until every column byte is in, then let the store writes finish
  task automatic settle;
    do @(posedge clk);
    while (pixel_q.size() != 0 || pix_ch.valid || column_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int   r;
    int   w_eff;
    int   w_new;
    int   b_new;
    int   count;
    logic at_band_start;
    pix_ch.valid      = 1'b0;
    pix_ch.pixel_byte = '0;
    col_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_WIDTH_BYTES;
    cfg_ch.data       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // zero registers clamp to a one byte wide, one band image
    write_reg(CFG_WIDTH_BYTES, 8'h00);
    write_reg(CFG_BAND_COUNT, 8'h00);
    write_reg(CFG_SPARE, 8'h5A);
    for (r = 0; r < BAND_ROWS; r++) pixel_q.push_back(CORNER_BYTES[r]);
    for (r = 0; r < BAND_ROWS; r++) pixel_q.push_back(8'hFF);
    for (r = 0; r < BAND_ROWS; r++) pixel_q.push_back(8'h80 >> r);
    items_sent += 3 * BAND_ROWS;
    settle;

    // oversized values saturate to full width and the tallest image
    idle_odds = 6;
    write_reg(CFG_WIDTH_BYTES, 8'hFF);
    write_reg(CFG_BAND_COUNT, 8'hFF);
    send_random(MAX_WIDTH_BYTES * BAND_ROWS);
    settle;

    // narrow down, then cut the band count below the band already reached
    idle_odds = 3;
    write_reg(CFG_WIDTH_BYTES, 8'd2);
    write_reg(CFG_BAND_COUNT, 8'd5);
    send_random(3 * 2 * BAND_ROWS);
    settle;
    write_reg(CFG_BAND_COUNT, 8'd2);
    send_random(2 * BAND_ROWS);
    settle;

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS - QUIET_TAIL) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_odds = 0;
          1:       idle_odds = 3;
          2:       idle_odds = 8;
          default: idle_odds = 20;
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 15))
          0:       w_new = 0;
          1:       w_new = $urandom_range(MAX_WIDTH_BYTES + 1, 31);
          2:       w_new = MAX_WIDTH_BYTES;
          default: w_new = $urandom_range(1, 4);
        endcase
        // widening is only safe at a band start, otherwise columns would be read unwritten
        at_band_start = (row_pos == 0) && (col_pos == 0);
        w_eff = clamp_width(width_reg);
        if (!at_band_start && clamp_width(WIDTH_W'(w_new)) > w_eff) w_new = $urandom_range(1, w_eff);
        write_reg(CFG_WIDTH_BYTES, {3'($urandom), WIDTH_W'(w_new)});
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       b_new = 0;
          1:       b_new = $urandom_range(MAX_BANDS + 1, 63);
          default: b_new = $urandom_range(1, 4);
        endcase
        write_reg(CFG_BAND_COUNT, {2'($urandom), BANDS_W'(b_new)});
      end
      w_eff = clamp_width(width_reg);
      if (w_eff > 4) count = w_eff * BAND_ROWS;
      else count = w_eff * BAND_ROWS * $urandom_range(1, 2);
      // sometimes stop partway into a band
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
      send_random(count);
      settle;
    end

    if (errors == 0) begin
      $display("tb_bitmap_row_to_page_bytes_core: done, clean");
    end else begin
      $display("tb_bitmap_row_to_page_bytes_core: done, errors");
    end
    $finish;
  end

endmodule
